### design/brf_pkg.sv
package brf_pkg;

	localparam int FRAC_BITS = 30;
	localparam int FIX_W     = 32;
	localparam int TOL_W     = 31;
	localparam int PW        = 48;
	localparam int HALF_W    = PW / 2;
	localparam int PP_W      = 2 * (HALF_W + 1);
	localparam int ACC_W     = FRAC_BITS + PW;

	localparam logic [PW-1:0] ONE_FX = PW'(1) << FRAC_BITS;

	localparam logic [2:0] OP_FIRST   = 3'd0;
	localparam logic [2:0] OP_X5      = 3'd2;
	localparam logic [2:0] OP_LAST_P1 = 3'd4;
	localparam logic [2:0] PH_LAST    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_FIN,
		ST_OUT
	} brf_state_t;

endpackage

### design/brf_in_if.sv
interface brf_in_if import brf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [FIX_W-1:0] left_end;
	logic [FIX_W-1:0] right_end;

	modport source (output valid, req_type, left_end, right_end, input ready);
	modport sink (input valid, req_type, left_end, right_end, output ready);
endinterface

### design/brf_out_if.sv
interface brf_out_if import brf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [FIX_W-1:0] root;

	modport source (output valid, root, input ready);
	modport sink (input valid, root, output ready);
endinterface

### design/bisection_root_finder.sv
// Bisection root finder for x^5+7x+1 (req_type 0) or 2x^11+17x^5+1 (req_type 1).
// An input beat on in_ch carries the selector and two interval ends in signed
// Q2.30; the matching output beat on out_ch carries the final midpoint.
// The block takes one beat at a time: in_ch.ready is high only while idle.
// Each halving evaluates the polynomial once at the midpoint; the value at the
// left end is evaluated once per beat and then carried along. Every fixed-point
// product runs on one shared 25 by 25 bit multiplier, which forms and sums four
// partial products of the operand halves; one evaluation takes three products
// for the first polynomial and five for the second. A beat needs at most about
// 32 iterations, and none when the ends already lie within the tolerance.
// The tolerance register is written through cfg_we and cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce. A
// zero tolerance behaves as one. Reset clears the sequencer and the output
// valid and sets the tolerance to one. A result waits in the output register
// while out_ch.ready is low, and the next input beat may be taken meanwhile.
module bisection_root_finder import brf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TOL_W-1:0] cfg_wdata,
	brf_in_if.sink           in_ch,
	brf_out_if.source        out_ch
);

	brf_state_t state_q, state_d;

	logic [TOL_W-1:0]       tol_q;
	logic                   sel_q;
	logic [FIX_W-1:0]       left_q, right_q;
	logic                   lk_q, sl_zero_q, sl_neg_q;
	logic [PW-1:0]          x_q, r_q, x5_q;
	logic [2:0]             op_q, ph_q;
	logic signed [PP_W-1:0] prod_q;
	logic [ACC_W-1:0]       acc_q;
	logic [FIX_W-1:0]       root_q;
	logic                   out_valid_q;

	logic                   in_acc;
	logic [FIX_W:0]         sum, diff, absd;
	logic [FIX_W-1:0]       mid;
	logic [TOL_W-1:0]       tol_eff;
	logic                   done;
	logic [PW-1:0]          opa, opb, mul_res, pval;
	logic signed [HALF_W:0] pa, pb;
	logic [1:0]             kd;
	logic [ACC_W-1:0]       term_ext, term, acc_sum;
	logic                   p_zero, p_neg, last_op, out_load;

	assign in_acc = in_ch.valid && in_ch.ready;

	assign sum     = {left_q[FIX_W-1], left_q} + {right_q[FIX_W-1], right_q};
	assign mid     = sum[FIX_W:1];
	assign diff    = {right_q[FIX_W-1], right_q} - {left_q[FIX_W-1], left_q};
	assign absd    = diff[FIX_W] ? (~diff + 1'b1) : diff;
	assign tol_eff = (tol_q == '0) ? TOL_W'(1) : tol_q;
	assign done    = absd <= {{(FIX_W + 1 - TOL_W){1'b0}}, tol_eff};

	assign opa = (op_q == OP_FIRST) ? x_q : r_q;
	assign opb = op_q[0] ? r_q : x_q;
	assign pa  = ph_q[1] ? {opa[PW-1], opa[PW-1:HALF_W]} : {1'b0, opa[HALF_W-1:0]};
	assign pb  = ph_q[0] ? {opb[PW-1], opb[PW-1:HALF_W]} : {1'b0, opb[HALF_W-1:0]};

	assign kd       = 2'(ph_q - 3'd1);
	assign term_ext = {{(ACC_W - PP_W){prod_q[PP_W-1]}}, prod_q};
	always_comb begin
		case (kd)
			2'd0:    term = term_ext;
			2'd3:    term = term_ext << (2 * HALF_W);
			default: term = term_ext << HALF_W;
		endcase
	end
	assign acc_sum = ((ph_q == 3'd1) ? '0 : acc_q) + term;
	assign mul_res = acc_sum[FRAC_BITS +: PW];
	assign last_op = (op_q == (sel_q ? OP_LAST_P1 : OP_X5));

	always_comb begin
		if (sel_q) begin
			pval = (r_q << 1) + (x5_q << 4) + x5_q + ONE_FX;
		end else begin
			pval = r_q + (x_q << 3) - x_q + ONE_FX;
		end
	end
	assign p_zero = (pval == '0);
	assign p_neg  = pval[PW-1];

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = done ? ST_OUT : ST_MUL;
			end
			ST_MUL: begin
				if (ph_q == PH_LAST && last_op) state_d = ST_FIN;
			end
			ST_FIN: begin
				state_d = ST_CHECK;
			end
			ST_OUT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready  = (state_q == ST_IDLE);
		out_ch.valid = out_valid_q;
		out_ch.root  = root_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			tol_q       <= TOL_W'(1);
		end else begin
			state_q <= state_d;
			if (cfg_we) tol_q <= cfg_wdata;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					sel_q   <= in_ch.req_type;
					left_q  <= in_ch.left_end;
					right_q <= in_ch.right_end;
					lk_q    <= 1'b0;
				end
			end
			ST_CHECK: begin
				if (lk_q) begin
					x_q <= {{(PW - FIX_W){mid[FIX_W-1]}}, mid};
				end else begin
					x_q <= {{(PW - FIX_W){left_q[FIX_W-1]}}, left_q};
				end
				op_q <= OP_FIRST;
				ph_q <= '0;
			end
			ST_MUL: begin
				if (ph_q != PH_LAST) prod_q <= pa * pb;
				if (ph_q != 3'd0) acc_q <= acc_sum;
				if (ph_q == PH_LAST) begin
					r_q  <= mul_res;
					if (op_q == OP_X5) x5_q <= mul_res;
					ph_q <= '0;
					op_q <= op_q + 3'd1;
				end else begin
					ph_q <= ph_q + 3'd1;
				end
			end
			ST_FIN: begin
				if (!lk_q) begin
					lk_q      <= 1'b1;
					sl_zero_q <= p_zero;
					sl_neg_q  <= p_neg;
				end else if (!sl_zero_q && !p_zero && (sl_neg_q != p_neg)) begin
					right_q <= mid;
				end else begin
					left_q    <= mid;
					sl_zero_q <= p_zero;
					sl_neg_q  <= p_neg;
				end
			end
			ST_OUT: begin
				if (out_load) root_q <= mid;
			end
			default: ;
		endcase
	end

endmodule

### verif/bisection_root_finder_tb.sv
module bisection_root_finder_tb import brf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint ROOT_P0 = -153391689;
	localparam longint ROOT_P1 = -609000000;
	localparam logic [FIX_W-1:0] MOST_NEG = 32'h8000_0000;
	localparam logic [FIX_W-1:0] MOST_POS = 32'h7FFF_FFFF;
	localparam logic [TOL_W-1:0] TOL_MAX = 31'h7FFF_FFFF;
	localparam logic SEL_P0 = 1'b0;
	localparam logic SEL_P1 = 1'b1;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [TOL_W-1:0] cfg_wdata;

	brf_in_if  in_ch ();
	brf_out_if out_ch ();

	bisection_root_finder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	logic [FIX_W-1:0] pending_roots[$];
	logic [TOL_W-1:0] tol_setting;
	bit steady;
	int failures;
	int idle_cycles;
	int requests_sent;
	int roots_checked;
	int tol_writes;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [PW-1:0] fx_mult(input logic signed [PW-1:0] a,
		input logic signed [PW-1:0] b);
		logic signed [2*PW-1:0] prod;
		prod = a * b;
		return prod[FRAC_BITS +: PW];
	endfunction

	function automatic logic signed [PW-1:0] eval_poly(input logic sel,
		input logic signed [FIX_W-1:0] x);
		logic signed [PW-1:0] xw, x2, x4, x5, x10, x11;
		xw = x;
		x2 = fx_mult(xw, xw);
		x4 = fx_mult(x2, x2);
		x5 = fx_mult(x4, xw);
		if (sel == SEL_P0) begin
			return x5 + 7 * xw + ONE_FX;
		end
		x10 = fx_mult(x5, x5);
		x11 = fx_mult(x10, xw);
		return 2 * x11 + 17 * x5 + ONE_FX;
	endfunction

	function automatic int poly_sign(input logic signed [PW-1:0] v);
		if (v == '0) begin
			return 0;
		end
		return v[PW-1] ? -1 : 1;
	endfunction

	function automatic logic [FIX_W-1:0] bisect_root(input logic sel,
		input logic [FIX_W-1:0] l_in, input logic [FIX_W-1:0] r_in,
		input logic [TOL_W-1:0] tol);
		longint lo, hi, mid, width, limit;
		int s_lo, s_mid;
		lo = longint'($signed(l_in));
		hi = longint'($signed(r_in));
		limit = (tol == '0) ? 64'sd1 : longint'(tol);
		width = hi - lo;
		while ((width < 0 ? -width : width) > limit) begin
			mid = (lo + hi) >>> 1;
			s_lo = poly_sign(eval_poly(sel, lo[FIX_W-1:0]));
			s_mid = poly_sign(eval_poly(sel, mid[FIX_W-1:0]));
			if (s_lo != 0 && s_mid != 0 && s_lo != s_mid) begin
				hi = mid;
			end else begin
				lo = mid;
			end
			width = hi - lo;
		end
		mid = (lo + hi) >>> 1;
		return mid[FIX_W-1:0];
	endfunction

	function automatic logic [FIX_W-1:0] clamp_fix(input longint v);
		if (v < -64'sd2147483648) begin
			return MOST_NEG;
		end
		if (v > 64'sd2147483647) begin
			return MOST_POS;
		end
		return v[FIX_W-1:0];
	endfunction

	function automatic logic [TOL_W-1:0] pick_tolerance();
		case ($urandom_range(3))
			0: return TOL_W'(1);
			1: return TOL_W'($urandom_range(255));
			2: return TOL_W'(1) << $urandom_range(TOL_W - 1);
			default: return TOL_W'($urandom);
		endcase
	endfunction

	// Every result is checked against the oldest pending root; the watchdog counter
	// restarts on any accepted beat in either direction.
	always @(posedge clk) begin
		logic [FIX_W-1:0] want;
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			roots_checked++;
			if (pending_roots.size() == 0) begin
				$error("root: no result expected, got %0d", $signed(out_ch.root));
				failures++;
			end else begin
				want = pending_roots.pop_front();
				if (out_ch.root !== want) begin
					$error("root: expected %0d, got %0d", $signed(want), $signed(out_ch.root));
					failures++;
				end
			end
		end
		out_ch.ready <= steady || ($urandom_range(99) >= 21);
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
		end
		$display("FAIL bisection_root_finder");
		$finish;
	end

	task automatic send_req(input logic sel, input logic [FIX_W-1:0] l,
		input logic [FIX_W-1:0] r);
		while (!steady && $urandom_range(99) < 21) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.req_type  <= sel;
		in_ch.left_end  <= l;
		in_ch.right_end <= r;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		pending_roots.push_back(bisect_root(sel, l, r, tol_setting));
		requests_sent++;
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_roots.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_tolerance(input logic [TOL_W-1:0] tol);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= tol;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_setting = tol;
		tol_writes++;
		@(posedge clk);
	endtask

	task automatic send_bracketed();
		logic sel;
		longint centre, below, above;
		sel = 1'($urandom_range(1));
		centre = (sel == SEL_P1) ? ROOT_P1 : ROOT_P0;
		below = longint'($urandom >> $urandom_range(31));
		above = longint'($urandom >> $urandom_range(31));
		if ($urandom_range(1) == 0) begin
			send_req(sel, clamp_fix(centre - below), clamp_fix(centre + above));
		end else begin
			send_req(sel, clamp_fix(centre + above), clamp_fix(centre - below));
		end
	endtask

	task automatic send_noise();
		logic sel;
		logic [FIX_W-1:0] a, b;
		longint centre;
		sel = 1'($urandom_range(1));
		a = $urandom;
		b = $urandom;
		centre = longint'($signed(a));
		case ($urandom_range(3))
			0: send_req(sel, a, b);
			1: send_req(sel, a, clamp_fix(centre + longint'($urandom >> $urandom_range(8, 31))));
			2: send_req(sel, ($urandom_range(1) == 0) ? MOST_NEG : MOST_POS, b);
			default: send_req(sel, a, a);
		endcase
	endtask

	task automatic test_reset_tolerance();
		send_req(SEL_P0, MOST_NEG, MOST_POS);
		send_req(SEL_P1, MOST_NEG, MOST_POS);
		send_req(SEL_P0, MOST_POS, MOST_NEG);
		send_req(SEL_P1, MOST_POS, MOST_NEG);
		send_req(SEL_P0, '0, '0);
		send_req(SEL_P1, clamp_fix(ROOT_P1), clamp_fix(ROOT_P1));
		send_req(SEL_P0, MOST_NEG, MOST_NEG);
		send_req(SEL_P1, MOST_POS, MOST_POS);
		send_req(SEL_P0, '0, MOST_POS);
		send_req(SEL_P1, MOST_NEG, '0);
		send_req(SEL_P0, '1, 32'd1);
		send_req(SEL_P0, '0, 32'd1);
	endtask

	task automatic test_tolerance_extremes();
		set_tolerance('0);
		send_req(SEL_P0, MOST_NEG, MOST_POS);
		send_req(SEL_P1, MOST_POS, MOST_NEG);
		send_req(SEL_P0, '1, 32'd1);
		set_tolerance(TOL_MAX);
		send_req(SEL_P0, MOST_NEG, MOST_POS);
		send_req(SEL_P1, MOST_POS, MOST_NEG);
		send_req(SEL_P0, '0, MOST_POS);
		set_tolerance(TOL_W'(2));
		send_req(SEL_P1, clamp_fix(ROOT_P1 - 1000000), clamp_fix(ROOT_P1 + 1000000));
		send_req(SEL_P0, clamp_fix(ROOT_P0 + 5000), clamp_fix(ROOT_P0 - 5000));
	endtask

	task automatic test_bracketed_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				set_tolerance(pick_tolerance());
			end
			send_bracketed();
		end
	endtask

	task automatic test_noise_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				set_tolerance(pick_tolerance());
			end
			send_noise();
		end
	endtask

	task automatic test_steady_stream(input int count);
		set_tolerance(TOL_W'(1));
		steady = 1'b1;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0) begin
				send_noise();
			end else begin
				send_bracketed();
			end
		end
		drain_results();
		steady = 1'b0;
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		in_ch.valid     = 1'b0;
		in_ch.req_type  = 1'b0;
		in_ch.left_end  = '0;
		in_ch.right_end = '0;
		tol_setting     = TOL_W'(1);
		steady          = 1'b0;
		requests_sent   = 0;
		tol_writes      = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_tolerance();
		test_tolerance_extremes();
		test_bracketed_random(1150);
		test_noise_random(300);
		test_steady_stream(150);

		drain_results();
		repeat (50) @(posedge clk);
		$display("Sent %0d requests over %0d tolerance writes and checked %0d roots.",
			requests_sent, tol_writes, roots_checked);
		$display("Both polynomials, bracketed, reversed, degenerate and random intervals.");
		if (failures == 0 && pending_roots.size() == 0) begin
			$display("PASS bisection_root_finder");
		end else begin
			$display("FAIL bisection_root_finder");
		end
		$finish;
	end

endmodule

### filelist.f
design/brf_pkg.sv
design/brf_in_if.sv
design/brf_out_if.sv
design/bisection_root_finder.sv
verif/bisection_root_finder_tb.sv
